/* src/morphogen_reaction_euler_step_unit_defines.svh */
// Assertion helpers shared by the reaction step unit.
`ifndef MORPHOGEN_REACTION_EULER_STEP_UNIT_DEFINES_SVH
`define MORPHOGEN_REACTION_EULER_STEP_UNIT_DEFINES_SVH

// Checks that cond in one cycle implies expr in the next, outside reset.
`define MRES_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mres check failed");

// Checks that cond implies expr in the same cycle, outside reset.
`define MRES_ASSERT_NOW(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mres check failed");

// Checks that cond implies expr in the next cycle, reset included.
`define MRES_ASSERT_ALWAYS_NEXT(lbl, clk, cond, expr) \
   lbl: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error("mres check failed");

`endif

/* src/mres_pkg.sv */
`timescale 1ns / 1ps
package mres_pkg;

   localparam int DIV_STAGES = 24;
   localparam int DIV_STEPS  = 2;

   localparam logic [48:0] Q_ONE   = 49'h1_0000;
   localparam logic [47:0] MAG_CAP = 48'hFFFF_FFFF_FFFF;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_WNT_GAIN   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WNT_SAT    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BMP_COUPLE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASAL      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NODAL_GAIN = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NODAL_SAT  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_NODAL_THR  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_BOUND_BMP  = 4'd7;

   // Fields that ride along with a voxel through the pipeline.
   typedef struct packed {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] b;
      logic               outside;
      logic signed [48:0] bterm;
      logic               clip;
   } side_type;

   // Four 24x24 partial products of a 48x48 multiply.
   typedef struct packed {
      logic [47:0] ll;
      logic [47:0] lh;
      logic [47:0] hl;
      logic [47:0] hh;
   } pp_type;

   typedef struct packed {
      logic        clip;
      logic [47:0] mag;
   } mul_res_type;

   // Restoring divider state: partial remainder and the shift word that
   // feeds dividend bits out of the top and takes quotient bits in below.
   typedef struct packed {
      logic [48:0] rem;
      logic [47:0] sh;
   } dstate_type;

   function automatic pp_type mul_pp(input logic [47:0] a, input logic [47:0] b);
      pp_type p;
      p.ll = 48'(a[23:0]) * 48'(b[23:0]);
      p.lh = 48'(a[23:0]) * 48'(b[47:24]);
      p.hl = 48'(a[47:24]) * 48'(b[23:0]);
      p.hh = 48'(a[47:24]) * 48'(b[47:24]);
      return p;
   endfunction

   // Sums the partial products, drops 16 fraction bits and clips the
   // magnitude when the full product does not fit in 64 bits.
   function automatic mul_res_type mul_fin(input pp_type p);
      logic [95:0] full;
      mul_res_type r;
      full = 96'(p.ll) + ((96'(p.lh) + 96'(p.hl)) << 24) + (96'(p.hh) << 48);
      r.clip = |full[95:64];
      r.mag  = r.clip ? MAG_CAP : full[63:16];
      return r;
   endfunction

   function automatic dstate_type div_step(input dstate_type s, input logic [48:0] den);
      logic [49:0] r2;
      dstate_type o;
      r2   = {s.rem, s.sh[47]};
      o.sh = {s.sh[46:0], 1'b0};
      if (r2 >= {1'b0, den}) begin
         r2      = r2 - {1'b0, den};
         o.sh[0] = 1'b1;
      end
      o.rem = r2[48:0];
      return o;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

endpackage

/* src/mres_div_pipe.sv */
`timescale 1ns / 1ps
module mres_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  mres_pkg::side_type    in_side,
   input  logic [47:0]           in_wnum,
   input  logic [48:0]           in_wden,
   input  logic [47:0]           in_nnum,
   input  logic [48:0]           in_nden,
   output logic                  out_vld,
   output mres_pkg::side_type    out_side,
   output logic [47:0]           out_wq,
   output logic [47:0]           out_nq
);

   localparam int NS = mres_pkg::DIV_STAGES;

   logic [NS-1:0]        vld_ff, vld_in;
   mres_pkg::side_type   side_ff [NS];
   mres_pkg::side_type   side_in [NS];
   mres_pkg::dstate_type ws_ff [NS];
   mres_pkg::dstate_type ws_in [NS];
   mres_pkg::dstate_type ns_ff [NS];
   mres_pkg::dstate_type ns_in [NS];
   logic [48:0]          wden_ff [NS];
   logic [48:0]          wden_in [NS];
   logic [48:0]          nden_ff [NS];
   logic [48:0]          nden_in [NS];

   // Each stage resolves DIV_STEPS quotient bits of both divisions.
   always_comb begin
      mres_pkg::dstate_type wcur;
      mres_pkg::dstate_type ncur;
      logic [48:0]          wd;
      logic [48:0]          nd;
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            wcur.rem  = {33'b0, in_wnum[47:32]};
            wcur.sh   = {in_wnum[31:0], 16'b0};
            ncur.rem  = {33'b0, in_nnum[47:32]};
            ncur.sh   = {in_nnum[31:0], 16'b0};
            wd        = in_wden;
            nd        = in_nden;
            vld_in[k] = in_vld;
            side_in[k] = in_side;
         end else begin
            wcur      = ws_ff[k-1];
            ncur      = ns_ff[k-1];
            wd        = wden_ff[k-1];
            nd        = nden_ff[k-1];
            vld_in[k] = vld_ff[k-1];
            side_in[k] = side_ff[k-1];
         end
         for (int j = 0; j < mres_pkg::DIV_STEPS; j++) begin
            wcur = mres_pkg::div_step(wcur, wd);
            ncur = mres_pkg::div_step(ncur, nd);
         end
         ws_in[k]   = wcur;
         ns_in[k]   = ncur;
         wden_in[k] = wd;
         nden_in[k] = nd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         ws_ff   <= ws_in;
         ns_ff   <= ns_in;
         wden_ff <= wden_in;
         nden_ff <= nden_in;
      end
   end

   assign out_vld  = vld_ff[NS-1];
   assign out_side = side_ff[NS-1];
   assign out_wq   = ws_ff[NS-1].sh;
   assign out_nq   = ns_ff[NS-1].sh;

endmodule

/* src/morphogen_reaction_euler_step_unit.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata {bmp, nodal, wnt}, tuser outside_ring
// rsp       out  rsp_tvalid/rsp_tready  tdata {bmp, nodal, wnt}, tuser saturated
// csr       in   csr_valid/csr_ready    csr_index, csr_wdata
//
// One item per cycle is accepted when the output side keeps up. The pipeline is made of
// the two 24-stage restoring dividers (two quotient bits per stage) plus seven stages
// in front and five behind them.
// Reset is synchronous and active high; it clears all valid bits and the configuration registers.
// The whole pipeline advances together; when the output item is held, every stage
// holds, so nothing is lost or repeated. The CSR port is always ready.
module morphogen_reaction_euler_step_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [95:0]                    req_tdata,  // wnt_density, nodal_density, bmp_density
   input  logic                           req_tuser,  // outside_ring
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [95:0]                    rsp_tdata,  // new_wnt, new_nodal, new_bmp
   output logic                           rsp_tuser,  // saturated
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mres_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

`include "morphogen_reaction_euler_step_unit_defines.svh"

   typedef struct packed {
      logic               clip;
      logic signed [31:0] val;
   } sat_type;

   localparam logic signed [51:0] SUM_MAX = 52'sd2147483647;
   localparam logic signed [51:0] SUM_MIN = -52'sd2147483648;

   // Clips a wide sum to the signed 32-bit range.
   function automatic sat_type sat32(input logic signed [51:0] x);
      sat_type r;
      if (x > SUM_MAX) begin
         r.clip = 1'b1;
         r.val  = 32'sh7FFF_FFFF;
      end else if (x < SUM_MIN) begin
         r.clip = 1'b1;
         r.val  = 32'sh8000_0000;
      end else begin
         r.clip = 1'b0;
         r.val  = x[31:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [30:0]        wnt_gain_ff, wnt_sat_ff, nodal_gain_ff, nodal_sat_ff;
   logic signed [31:0] bmp_couple_ff, basal_ff, nodal_thr_ff, bound_bmp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wnt_gain_ff   <= '0;
         wnt_sat_ff    <= '0;
         bmp_couple_ff <= '0;
         basal_ff      <= '0;
         nodal_gain_ff <= '0;
         nodal_sat_ff  <= '0;
         nodal_thr_ff  <= '0;
         bound_bmp_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mres_pkg::REG_WNT_GAIN:   wnt_gain_ff   <= csr_wdata[30:0];
            mres_pkg::REG_WNT_SAT:    wnt_sat_ff    <= csr_wdata[30:0];
            mres_pkg::REG_BMP_COUPLE: bmp_couple_ff <= csr_wdata;
            mres_pkg::REG_BASAL:      basal_ff      <= csr_wdata;
            mres_pkg::REG_NODAL_GAIN: nodal_gain_ff <= csr_wdata[30:0];
            mres_pkg::REG_NODAL_SAT:  nodal_sat_ff  <= csr_wdata[30:0];
            mres_pkg::REG_NODAL_THR:  nodal_thr_ff  <= csr_wdata;
            mres_pkg::REG_BOUND_BMP:  bound_bmp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline moves as one whenever the output register is free or drained.
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage valid bits.
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff, g_vld_ff;
   logic h_vld_ff, i_vld_ff, j_vld_ff, k_vld_ff, o_vld_ff;
   logic q_vld;

   // Stage A: registered input with magnitudes.
   logic signed [31:0] a_u_ff, a_v_ff, a_b_ff;
   logic               a_out_ff;
   logic [31:0]        a_umag_ff, a_vmag_ff, a_bmag_ff;

   // Stage B: squares, the BMP4 coupling term and the NODAL numerator.
   mres_pkg::side_type b_side_ff, b_side_in;
   logic [47:0]        b_u2_ff, b_v2_ff, b_nnum_ff;
   logic [63:0]        b_u2p, b_v2p, b_bp, b_np;
   logic [47:0]        b_bmag;

   // Stage C: partial products of u^4, A*u^2 and kv*v^2.
   mres_pkg::side_type c_side_ff;
   mres_pkg::pp_type   c_u4pp_ff, c_wnpp_ff, c_kvpp_ff;
   logic [47:0]        c_nnum_ff;

   // Stage D: finished products.
   mres_pkg::side_type    d_side_ff, d_side_in;
   logic [47:0]           d_u4_ff, d_wnum_ff, d_kvv2_ff, d_nnum_ff;
   mres_pkg::mul_res_type d_u4, d_wn, d_kv;

   // Stage E: partial products of ku*u^4, NODAL denominator.
   mres_pkg::side_type e_side_ff;
   mres_pkg::pp_type   e_kupp_ff;
   logic [47:0]        e_wnum_ff, e_nnum_ff;
   logic [48:0]        e_nden_ff;

   // Stage F: ku*u^4 finished.
   mres_pkg::side_type    f_side_ff, f_side_in;
   mres_pkg::mul_res_type f_ku;
   logic [47:0]           f_kuu4_ff, f_wnum_ff, f_nnum_ff;
   logic [48:0]           f_nden_ff;

   // Stage G: WNT denominator; feeds the dividers.
   mres_pkg::side_type g_side_ff;
   logic [47:0]        g_wnum_ff, g_nnum_ff;
   logic [48:0]        g_wden_ff, g_nden_ff;

   // Divider outputs.
   mres_pkg::side_type q_side;
   logic [47:0]        q_wq, q_nq;

   // Stage H: new WNT.
   mres_pkg::side_type h_side_ff, h_side_in;
   logic signed [51:0] h_sum;
   sat_type            h_sat;
   logic signed [31:0] h_newu_ff;
   logic               h_ge_ff;
   logic [47:0]        h_gmag_ff;

   // Stage I: selected NODAL multiplier.
   mres_pkg::side_type i_side_ff;
   logic signed [31:0] i_newu_ff, i_sel;
   logic [47:0]        i_gmag_ff;
   logic [31:0]        i_selmag_ff;
   logic               i_neg_ff;

   // Stage J: partial products of the NODAL increment.
   mres_pkg::side_type j_side_ff;
   logic signed [31:0] j_newu_ff;
   mres_pkg::pp_type   j_incpp_ff;
   logic               j_neg_ff;

   // Stage K: signed NODAL increment.
   mres_pkg::side_type    k_side_ff, k_side_in;
   mres_pkg::mul_res_type k_inc;
   logic signed [31:0]    k_newu_ff;
   logic signed [48:0]    k_inc_ff;

   // Stage L: output register.
   logic signed [51:0] o_sum;
   sat_type            o_sat;
   logic signed [31:0] o_newu_ff, o_newv_ff, o_newb_ff;
   logic               o_satf_ff;

   always_comb begin
      b_u2p  = 64'(a_umag_ff) * 64'(a_umag_ff);
      b_v2p  = 64'(a_vmag_ff) * 64'(a_vmag_ff);
      b_bp   = 64'(mres_pkg::mag32(bmp_couple_ff)) * 64'(a_bmag_ff);
      b_np   = 64'(nodal_gain_ff) * 64'(a_vmag_ff);
      b_bmag = b_bp[63:16];
      b_side_in.u       = a_u_ff;
      b_side_in.v       = a_v_ff;
      b_side_in.b       = a_b_ff;
      b_side_in.outside = a_out_ff;
      b_side_in.bterm   = (bmp_couple_ff[31] ^ a_b_ff[31]) ? -$signed({1'b0, b_bmag})
                                                          : $signed({1'b0, b_bmag});
      b_side_in.clip    = 1'b0;
   end

   always_comb begin
      d_u4 = mres_pkg::mul_fin(c_u4pp_ff);
      d_wn = mres_pkg::mul_fin(c_wnpp_ff);
      d_kv = mres_pkg::mul_fin(c_kvpp_ff);
      d_side_in      = c_side_ff;
      d_side_in.clip = c_side_ff.clip | d_u4.clip | d_wn.clip | d_kv.clip;
      f_ku = mres_pkg::mul_fin(e_kupp_ff);
      f_side_in      = e_side_ff;
      f_side_in.clip = e_side_ff.clip | f_ku.clip;
   end

   mres_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (g_vld_ff),
      .in_side  (g_side_ff),
      .in_wnum  (g_wnum_ff),
      .in_wden  (g_wden_ff),
      .in_nnum  (g_nnum_ff),
      .in_nden  (g_nden_ff),
      .out_vld  (q_vld),
      .out_side (q_side),
      .out_wq   (q_wq),
      .out_nq   (q_nq)
   );

   always_comb begin
      // u + f + B*b + C, exact, then clipped.
      h_sum = 52'(q_side.u) + 52'($signed({1'b0, q_wq})) + 52'(q_side.bterm)
            + 52'(basal_ff);
      h_sat = sat32(h_sum);
      h_side_in      = q_side;
      h_side_in.clip = q_side.clip | h_sat.clip;
      i_sel = h_ge_ff ? h_side_ff.v : h_newu_ff;
      k_inc = mres_pkg::mul_fin(j_incpp_ff);
      k_side_in      = j_side_ff;
      k_side_in.clip = j_side_ff.clip | k_inc.clip;
      o_sum = 52'(k_side_ff.v) + 52'(k_inc_ff);
      o_sat = sat32(o_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
         k_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= q_vld;
         i_vld_ff <= h_vld_ff;
         j_vld_ff <= i_vld_ff;
         k_vld_ff <= j_vld_ff;
         o_vld_ff <= k_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_u_ff    <= req_tdata[31:0];
         a_v_ff    <= req_tdata[63:32];
         a_b_ff    <= req_tdata[95:64];
         a_out_ff  <= req_tuser;
         a_umag_ff <= mres_pkg::mag32(req_tdata[31:0]);
         a_vmag_ff <= mres_pkg::mag32(req_tdata[63:32]);
         a_bmag_ff <= mres_pkg::mag32(req_tdata[95:64]);

         b_side_ff <= b_side_in;
         b_u2_ff   <= b_u2p[63:16];
         b_v2_ff   <= b_v2p[63:16];
         b_nnum_ff <= b_np[63:16];

         c_side_ff <= b_side_ff;
         c_u4pp_ff <= mres_pkg::mul_pp(b_u2_ff, b_u2_ff);
         c_wnpp_ff <= mres_pkg::mul_pp({17'b0, wnt_gain_ff}, b_u2_ff);
         c_kvpp_ff <= mres_pkg::mul_pp({17'b0, nodal_sat_ff}, b_v2_ff);
         c_nnum_ff <= b_nnum_ff;

         d_side_ff <= d_side_in;
         d_u4_ff   <= d_u4.mag;
         d_wnum_ff <= d_wn.mag;
         d_kvv2_ff <= d_kv.mag;
         d_nnum_ff <= c_nnum_ff;

         e_side_ff <= d_side_ff;
         e_kupp_ff <= mres_pkg::mul_pp({17'b0, wnt_sat_ff}, d_u4_ff);
         e_wnum_ff <= d_wnum_ff;
         e_nnum_ff <= d_nnum_ff;
         e_nden_ff <= mres_pkg::Q_ONE + {1'b0, d_kvv2_ff};

         f_side_ff <= f_side_in;
         f_kuu4_ff <= f_ku.mag;
         f_wnum_ff <= e_wnum_ff;
         f_nnum_ff <= e_nnum_ff;
         f_nden_ff <= e_nden_ff;

         g_side_ff <= f_side_ff;
         g_wnum_ff <= f_wnum_ff;
         g_nnum_ff <= f_nnum_ff;
         g_wden_ff <= mres_pkg::Q_ONE + {1'b0, f_kuu4_ff};
         g_nden_ff <= f_nden_ff;

         h_side_ff <= h_side_in;
         h_newu_ff <= h_sat.val;
         h_ge_ff   <= q_side.v >= nodal_thr_ff;
         h_gmag_ff <= q_nq;

         // The increment is negative when v and the selected factor differ in sign.
         i_side_ff   <= h_side_ff;
         i_newu_ff   <= h_newu_ff;
         i_gmag_ff   <= h_gmag_ff;
         i_selmag_ff <= mres_pkg::mag32(i_sel);
         i_neg_ff    <= h_side_ff.v[31] ^ i_sel[31];

         j_side_ff  <= i_side_ff;
         j_newu_ff  <= i_newu_ff;
         j_incpp_ff <= mres_pkg::mul_pp(i_gmag_ff, {16'b0, i_selmag_ff});
         j_neg_ff   <= i_neg_ff;

         k_side_ff <= k_side_in;
         k_newu_ff <= j_newu_ff;
         k_inc_ff  <= j_neg_ff ? -$signed({1'b0, k_inc.mag}) : $signed({1'b0, k_inc.mag});

         o_newu_ff <= k_newu_ff;
         o_newv_ff <= o_sat.val;
         o_newb_ff <= k_side_ff.outside ? bound_bmp_ff : k_side_ff.b;
         o_satf_ff <= k_side_ff.clip | o_sat.clip;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {o_newb_ff, o_newv_ff, o_newu_ff};
   assign rsp_tuser  = o_satf_ff;

   // A held output freezes the stages around the dividers.
   `MRES_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready,
                     $stable(h_vld_ff) && $stable(k_vld_ff) && $stable(g_vld_ff))
   // A new output item can only come from the stage in front of it.
   `MRES_ASSERT_NOW(a_out_source, clock, reset, $rose(o_vld_ff), $past(k_vld_ff))
   // Reset empties the output register.
   `MRES_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule
